>>> src/kalman_height_grid_update_assert.svh
// Assertion macros for the height grid update block.
`ifndef KALMAN_HEIGHT_GRID_UPDATE_ASSERT_SVH
`define KALMAN_HEIGHT_GRID_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define KHG_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("kalman_height_grid_update: assertion failed");
// Next-cycle implication.
`define KHG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("kalman_height_grid_update: assertion failed");
`else
`define KHG_ASSERT_NOW(label, clk, rstn, ante, cons)
`define KHG_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> src/khgu_pkg.sv
`timescale 1ns / 1ps
package khgu_pkg;
	localparam int ROW_BITS   = 7;
	localparam int COL_BITS   = 7;
	localparam int CELL_SHIFT = 7;
	localparam int ADDR_W     = ROW_BITS + COL_BITS;

	localparam logic [16:0] HALF_PI_Q16 = 17'd102944;

	// register indexes
	localparam logic [2:0] REG_ADAPTIVE = 3'd0;
	localparam logic [2:0] REG_BASE     = 3'd1;
	localparam logic [2:0] REG_DGAIN    = 3'd2;
	localparam logic [2:0] REG_AGAIN    = 3'd3;
	localparam logic [2:0] REG_FLOOR    = 3'd4;
	localparam logic [2:0] REG_CEIL     = 3'd5;
	localparam logic [2:0] REG_ORIGIN_X = 3'd6;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd7;

	typedef struct packed {
		logic               filled;
		logic signed [23:0] height;
		logic [23:0]        variance;
		logic signed [23:0] low;
		logic signed [23:0] high;
		logic [15:0]        count;
	} cell_t;

	// arctangent of 2^-i in Q16 rad
	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] r;
		case (i)
			4'd0:  r = 17'd51472;
			4'd1:  r = 17'd30386;
			4'd2:  r = 17'd16055;
			4'd3:  r = 17'd8150;
			4'd4:  r = 17'd4091;
			4'd5:  r = 17'd2047;
			4'd6:  r = 17'd1024;
			4'd7:  r = 17'd512;
			4'd8:  r = 17'd256;
			4'd9:  r = 17'd128;
			4'd10: r = 17'd64;
			4'd11: r = 17'd32;
			4'd12: r = 17'd16;
			4'd13: r = 17'd8;
			4'd14: r = 17'd4;
			default: r = 17'd2;
		endcase
		return r;
	endfunction
endpackage

>>> src/kalman_height_grid_update.sv
`timescale 1ns / 1ps
// Height grid update: each point (x, y, z in Q10 m) selects a cell by offset
// and shift, gets a variance and is fused into the cell by a scalar Kalman
// step; one result per point is returned with the cell's new values and a
// confidence. The time a point takes is set by one shared multiplier and a
// one-bit-per-cycle 50-step divider used up to three times (height step, new
// variance, confidence), plus, in adaptive mode only, a 24-step square root and
// a 16-step CORDIC for the angle term; a point off the map skips all of them.
// Seeding an empty cell skips the first two divisions. A cell variance at or
// above the ceiling skips the confidence division. The block is ready for the
// next point in the cycle after the result register is loaded, and a result
// still waiting on out_ready holds the sequencer before it loads the next one.
// After reset the cell store is swept clear, all 16384 (2^(ROW_BITS+COL_BITS))
// cells, before the first point is taken. Configuration writes take effect at
// once, so write them only while no point is in flight.
module kalman_height_grid_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        in_map,
	output logic [6:0]  cell_row,
	output logic [6:0]  cell_col,
	output logic signed [23:0] fused_height,
	output logic [23:0] fused_variance,
	output logic signed [23:0] lowest_height,
	output logic signed [23:0] highest_height,
	output logic [15:0] hit_count,
	output logic [15:0] confidence
);
	import khgu_pkg::*;
	`include "kalman_height_grid_update_assert.svh"

	typedef enum logic [17:0] {
		S_CLEAR  = 18'(1 << 0),
		S_IDLE   = 18'(1 << 1),
		S_LOOK   = 18'(1 << 2),
		S_SQ     = 18'(1 << 3),
		S_DG     = 18'(1 << 4),
		S_SQRT   = 18'(1 << 5),
		S_CORDIC = 18'(1 << 6),
		S_AG1    = 18'(1 << 7),
		S_AG2    = 18'(1 << 8),
		S_CLAMP  = 18'(1 << 9),
		S_MERGE  = 18'(1 << 10),
		S_HMUL   = 18'(1 << 11),
		S_HDIV   = 18'(1 << 12),
		S_VMUL   = 18'(1 << 13),
		S_VDIV   = 18'(1 << 14),
		S_WR     = 18'(1 << 15),
		S_CDIV   = 18'(1 << 16),
		S_OUT    = 18'(1 << 17)
	} state_t;

	localparam int DIV_W = 50;

	// configuration registers
	logic        adaptive_q;
	logic [23:0] base_q, floor_q, ceil_q;
	logic [15:0] dgain_q, again_q;
	logic signed [23:0] ox_q, oy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_q <= 1'b1;
			base_q     <= 24'd655;
			dgain_q    <= 16'd66;
			again_q    <= 16'd655;
			floor_q    <= 24'd66;
			ceil_q     <= 24'd65536;
			ox_q       <= '0;
			oy_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ADAPTIVE: adaptive_q <= cfg_data[0];
				REG_BASE:     base_q     <= cfg_data;
				REG_DGAIN:    dgain_q    <= cfg_data[15:0];
				REG_AGAIN:    again_q    <= cfg_data[15:0];
				REG_FLOOR:    floor_q    <= cfg_data;
				REG_CEIL:     ceil_q     <= cfg_data;
				REG_ORIGIN_X: ox_q       <= cfg_data;
				REG_ORIGIN_Y: oy_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell store
	cell_t              mem [2**ADDR_W];
	cell_t              mem_rd_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	cell_t              mem_wd;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q, idx_q;
	logic [5:0]         cnt_q;
	logic               in_map_q;
	logic [6:0]         row_q, col_q;
	logic signed [23:0] z_q;
	logic [23:0]        ax_q, ay_q, az_q;
	logic [46:0]        h2_q;
	logic [47:0]        d2_q;
	logic [45:0]        v_q;
	logic [23:0]        pv_q;
	logic [47:0]        sq_n_q, sq_res_q, sq_bit_q;
	logic signed [43:0] vx_q, vy_q;
	logic signed [18:0] ang_q;
	logic [16:0]        a_q;
	logic [32:0]        t_q;
	logic [24:0]        s_q, mag_q;
	logic               neg_q;
	logic [DIV_W-1:0]   dnum_q;
	logic [24:0]        drem_q, dden_q;
	logic signed [23:0] r_h_q, r_lo_q, r_hi_q;
	logic [23:0]        r_v_q;
	logic [15:0]        r_cnt_q, r_conf_q;
	logic               out_valid_q;
	logic               out_load;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[idx_q];
	end

	// angle clamped to [0, pi/2]
	logic [16:0] a_clamp;
	assign a_clamp = (ang_q < 0) ? 17'd0
		: (ang_q > 19'(HALF_PI_Q16)) ? HALF_PI_Q16 : ang_q[16:0];

	// shared multiplier
	logic [33:0] mul_a;
	logic [27:0] mul_b;
	logic [61:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				case (cnt_q[1:0])
					2'd0:    begin mul_a = 34'(ax_q); mul_b = 28'(ax_q); end
					2'd1:    begin mul_a = 34'(ay_q); mul_b = 28'(ay_q); end
					default: begin mul_a = 34'(az_q); mul_b = 28'(az_q); end
				endcase
			end
			S_DG: begin
				mul_a = 34'(dgain_q);
				mul_b = cnt_q[0] ? 28'(d2_q[19:0]) : d2_q[47:20];
			end
			S_AG1:   begin mul_a = 34'(again_q); mul_b = 28'(a_clamp); end
			S_AG2:   begin mul_a = 34'(t_q);     mul_b = 28'(a_q); end
			S_HMUL:  begin mul_a = 34'(mem_rd_q.variance); mul_b = 28'(mag_q); end
			S_VMUL:  begin mul_a = 34'(mem_rd_q.variance); mul_b = 28'(pv_q); end
			default: ;
		endcase
		prod = 62'(mul_a) * 62'(mul_b);
	end

	// divider step: one quotient bit a cycle
	logic [25:0] rem_sh;
	logic        div_ge;
	assign rem_sh = {drem_q, dnum_q[DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, dden_q};

	// cell mapping
	logic signed [24:0] dx, dy, rowf, colf;
	assign dx   = 25'(point_x) - 25'(ox_q);
	assign dy   = 25'(point_y) - 25'(oy_q);
	assign rowf = dx >>> CELL_SHIFT;
	assign colf = dy >>> CELL_SHIFT;

	// square root and CORDIC steps
	logic [47:0]        sq_t;
	logic signed [43:0] sh_x, sh_y;
	assign sq_t = sq_res_q + sq_bit_q;
	assign sh_x = vx_q >>> cnt_q[3:0];
	assign sh_y = vy_q >>> cnt_q[3:0];

	// fusion helpers
	logic signed [24:0] diff;
	logic [24:0]        s_sum;
	logic [45:0]        v_clamp;
	assign diff    = 25'(z_q) - 25'(mem_rd_q.height);
	assign s_sum   = 25'(mem_rd_q.variance) + 25'(pv_q);
	assign v_clamp = (v_q < 46'(floor_q)) ? 46'(floor_q) : v_q;

	// store write
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
		end else if (state_q == S_WR) begin
			mem_we = 1'b1;
			mem_wd = '{filled: 1'b1, height: r_h_q, variance: r_v_q,
				low: r_lo_q, high: r_hi_q, count: r_cnt_q};
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: begin
					cnt_q <= '0;
					if (!in_map_q) state_q <= S_OUT;
					else if (adaptive_q) state_q <= S_SQ;
					else state_q <= S_MERGE;
				end
				S_SQ: begin
					if (cnt_q == 6'd2) begin
						cnt_q   <= '0;
						state_q <= S_DG;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_DG: begin
					if (cnt_q == 6'd1) begin
						cnt_q   <= '0;
						state_q <= (d2_q >= 48'd2) ? S_SQRT : S_CLAMP;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_SQRT: begin
					if (cnt_q == 6'd23) begin
						cnt_q   <= '0;
						state_q <= S_CORDIC;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_CORDIC: begin
					if (cnt_q == 6'd15) begin
						cnt_q   <= '0;
						state_q <= S_AG1;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_AG1:   state_q <= S_AG2;
				S_AG2:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_MERGE;
				S_MERGE: begin
					cnt_q <= '0;
					if (!mem_rd_q.filled || s_sum == '0) state_q <= S_WR;
					else state_q <= S_HMUL;
				end
				S_HMUL: state_q <= S_HDIV;
				S_HDIV: begin
					if (cnt_q == 6'(DIV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_VMUL;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_VMUL: state_q <= S_VDIV;
				S_VDIV: begin
					if (cnt_q == 6'(DIV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_WR;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_WR: begin
					cnt_q <= '0;
					if (ceil_q == '0 || r_v_q >= ceil_q) state_q <= S_OUT;
					else state_q <= S_CDIV;
				end
				S_CDIV: begin
					if (cnt_q == 6'(DIV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_OUT;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					in_map_q <= (dx[24:CELL_SHIFT+ROW_BITS] == '0)
						&& (dy[24:CELL_SHIFT+COL_BITS] == '0);
					row_q    <= rowf[6:0];
					col_q    <= colf[6:0];
					idx_q    <= {rowf[ROW_BITS-1:0], colf[COL_BITS-1:0]};
					z_q      <= point_z;
					ax_q     <= point_x[23] ? 24'(-point_x) : point_x;
					ay_q     <= point_y[23] ? 24'(-point_y) : point_y;
					az_q     <= point_z[23] ? 24'(-point_z) : point_z;
				end
			end
			S_LOOK: begin
				pv_q     <= base_q;
				r_h_q    <= '0;
				r_v_q    <= '0;
				r_lo_q   <= '0;
				r_hi_q   <= '0;
				r_cnt_q  <= '0;
				r_conf_q <= '0;
			end
			S_SQ: begin
				case (cnt_q[1:0])
					2'd0:    h2_q <= prod[46:0];
					2'd1:    h2_q <= h2_q + prod[46:0];
					default: d2_q <= 48'(h2_q) + 48'(prod[46:0]);
				endcase
			end
			S_DG: begin
				if (cnt_q[0]) v_q <= v_q + 46'(prod[61:20]);
				else v_q <= 46'(base_q) + 46'(prod);
				sq_n_q   <= 48'(h2_q);
				sq_res_q <= '0;
				sq_bit_q <= 48'(1) << 46;
			end
			S_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q   <= sq_n_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				vx_q  <= 44'({az_q, 16'd0});
				vy_q  <= 44'({sq_res_q[24:1] + (sq_n_q >= sq_t ? 24'(sq_bit_q) : 24'd0),
					16'd0});
				ang_q <= '0;
			end
			S_CORDIC: begin
				if (vy_q > 0) begin
					vx_q  <= vx_q + sh_y;
					vy_q  <= vy_q - sh_x;
					ang_q <= ang_q + 19'(atan_q16(cnt_q[3:0]));
				end else begin
					vx_q  <= vx_q - sh_y;
					vy_q  <= vy_q + sh_x;
					ang_q <= ang_q - 19'(atan_q16(cnt_q[3:0]));
				end
			end
			// gain times angle, then times angle again into the variance
			S_AG1: begin
				a_q <= a_clamp;
				t_q <= prod[32:0];
			end
			S_AG2: begin
				v_q <= v_q + 46'(prod[61:32]);
			end
			S_CLAMP: begin
				pv_q <= (v_clamp > 46'(ceil_q)) ? ceil_q : v_clamp[23:0];
			end
			S_MERGE: begin
				s_q   <= s_sum;
				neg_q <= diff < 0;
				mag_q <= diff < 0 ? 25'(-diff) : diff;
				if (!mem_rd_q.filled) begin
					r_h_q   <= z_q;
					r_lo_q  <= z_q;
					r_hi_q  <= z_q;
					r_v_q   <= pv_q;
					r_cnt_q <= 16'd1;
				end else begin
					r_h_q   <= mem_rd_q.height;
					r_v_q   <= '0;
					r_lo_q  <= (z_q < mem_rd_q.low) ? z_q : mem_rd_q.low;
					r_hi_q  <= (z_q > mem_rd_q.high) ? z_q : mem_rd_q.high;
					r_cnt_q <= (&mem_rd_q.count) ? mem_rd_q.count
						: mem_rd_q.count + 1'b1;
				end
			end
			S_HMUL, S_VMUL: begin
				dnum_q <= DIV_W'(prod[47:0]) + DIV_W'(s_q[24:1]);
				drem_q <= '0;
				dden_q <= s_q;
			end
			S_HDIV, S_VDIV, S_CDIV: begin
				drem_q <= div_ge ? 25'(rem_sh - {1'b0, dden_q}) : rem_sh[24:0];
				dnum_q <= {dnum_q[DIV_W-2:0], div_ge};
				if (state_q == S_HDIV && cnt_q == 6'(DIV_W - 1))
					r_h_q <= neg_q ? 24'(r_h_q - {dnum_q[23:0], div_ge})
						: 24'(r_h_q + {dnum_q[23:0], div_ge});
				if (state_q == S_VDIV && cnt_q == 6'(DIV_W - 1))
					r_v_q <= {dnum_q[22:0], div_ge};
				if (state_q == S_CDIV && cnt_q == 6'(DIV_W - 1))
					r_conf_q <= ({dnum_q[15:0], div_ge} == 17'd0) ? 16'hFFFF
						: 16'(17'h10000 - {dnum_q[15:0], div_ge});
			end
			S_WR: begin
				dnum_q <= DIV_W'({r_v_q, 16'd0});
				drem_q <= '0;
				dden_q <= 25'(ceil_q);
			end
			default: ;
		endcase
	end

	// result register
	logic        o_map_q;
	logic [6:0]  o_row_q, o_col_q;
	logic signed [23:0] o_h_q, o_lo_q, o_hi_q;
	logic [23:0] o_v_q;
	logic [15:0] o_cnt_q, o_conf_q;
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_map_q  <= in_map_q;
			o_row_q  <= in_map_q ? row_q : 7'd0;
			o_col_q  <= in_map_q ? col_q : 7'd0;
			o_h_q    <= r_h_q;
			o_v_q    <= r_v_q;
			o_lo_q   <= r_lo_q;
			o_hi_q   <= r_hi_q;
			o_cnt_q  <= r_cnt_q;
			o_conf_q <= r_conf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign in_map         = o_map_q;
	assign cell_row       = o_row_q;
	assign cell_col       = o_col_q;
	assign fused_height   = o_h_q;
	assign fused_variance = o_v_q;
	assign lowest_height  = o_lo_q;
	assign highest_height = o_hi_q;
	assign hit_count      = o_cnt_q;
	assign confidence     = o_conf_q;

	`KHG_ASSERT_NEXT(a_accept_look, clk, arst_n, in_valid && in_ready, state_q == S_LOOK)
	`KHG_ASSERT_NEXT(a_out_hold, clk, arst_n, state_q == S_OUT && out_valid_q && !out_ready,
		state_q == S_OUT)
	`KHG_ASSERT_NOW(a_write_state, clk, arst_n, mem_we, state_q == S_CLEAR || state_q == S_WR)
	`KHG_ASSERT_NOW(a_count_nonzero, clk, arst_n, out_valid && in_map, hit_count != 16'd0)
endmodule
